// ----- sv/prf_pkg.sv -----
// Package for the page frame replacement unit.
// Holds the field widths, the parameter defaults and the policy codes.
// It depends on nothing else.
package prf_pkg;

   localparam int FRAMES_DEFAULT = 8;
   localparam int PAGES_DEFAULT  = 64;

   localparam int PAGE_NUMBER_W = 6;
   localparam int FRAME_INDEX_W = 3;
   localparam int FAULT_W       = 16;
   localparam int POLICY_W      = 2;

   typedef enum logic [POLICY_W-1:0] {
      POLICY_FIFO = 2'd0,
      POLICY_LRU  = 2'd1,
      POLICY_MRU  = 2'd2
   } policy_type;

endpackage

// ----- sv/prf_cell.sv -----
// One cell of the recency chain: a frame number, the page that owns it and a valid flag.
// On a shift it loads the contents of its neighbour nearer the head of the chain.
// It depends on prf_pkg.
module prf_cell
   import prf_pkg::*;
#(
   parameter int FRAME_W = 3,
   parameter int PAGE_W  = PAGE_NUMBER_W
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               shift_en,
   input  logic               in_valid,
   input  logic [FRAME_W-1:0] in_frame,
   input  logic [PAGE_W-1:0]  in_owner,
   input  logic [PAGE_W-1:0]  query_page,
   input  logic [FRAME_W-1:0] query_frame,
   output logic               valid,
   output logic [FRAME_W-1:0] frame,
   output logic [PAGE_W-1:0]  owner,
   output logic               page_match,
   output logic               frame_match
);

   logic               valid_ff;
   logic [FRAME_W-1:0] frame_ff;
   logic [PAGE_W-1:0]  owner_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (shift_en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         frame_ff <= in_frame;
         owner_ff <= in_owner;
      end
   end

   assign valid       = valid_ff;
   assign frame       = frame_ff;
   assign owner       = owner_ff;
   assign page_match  = valid_ff && (owner_ff == query_page);
   assign frame_match = valid_ff && (frame_ff == query_frame);

endmodule

// ----- sv/page_frame_replacement_unit.sv -----
// Page frame replacement unit with FIFO, LRU and MRU policies. A request is taken at
// every clock edge at which start is high, as busy stays low, and its response appears on
// the rsp_ ports, marked by rsp_valid, for exactly one cycle, registered at the edge that took it:
// one request per cycle. The receiver cannot stall the
// responses, so it must take each one in the cycle in which it is shown. The frames form a
// chain of cells in recency order, each carrying its frame number and owner page, so that
// the lookup is a compare in every cell and a move to the front is one shift of the chosen cell and the cells
// ahead of it. Reset empties all frames and clears the fault count; the policy
// register should be written only after a reset and while no request is in flight.
// It depends on prf_pkg and prf_cell.
module page_frame_replacement_unit
   import prf_pkg::*;
#(
   parameter int NUM_FRAMES = FRAMES_DEFAULT,
   parameter int NUM_PAGES  = PAGES_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [PAGE_NUMBER_W-1:0] req_page_number,
   output logic                     rsp_valid,
   output logic                     rsp_hit,
   output logic [FRAME_INDEX_W-1:0] rsp_frame_index,
   output logic                     rsp_evicted_valid,
   output logic [PAGE_NUMBER_W-1:0] rsp_evicted_page,
   output logic [FAULT_W-1:0]       rsp_fault_count,
   input  logic                     csr_write_enable,
   input  logic [POLICY_W-1:0]      csr_write_data
);

   localparam int FRAME_W = $clog2(NUM_FRAMES);
   localparam int PAGE_W  = (NUM_PAGES >= (1 << PAGE_NUMBER_W)) ?
                            PAGE_NUMBER_W : $clog2(NUM_PAGES);
   localparam int FILL_W  = $clog2(NUM_FRAMES + 1);

   logic [POLICY_W-1:0]      policy_ff;
   logic [FILL_W-1:0]        filled_ff;
   logic [FRAME_W-1:0]       fifo_ff;
   logic [FAULT_W-1:0]       fault_ff;
   logic                     rsp_valid_ff;
   logic                     rsp_hit_ff;
   logic [FRAME_INDEX_W-1:0] rsp_frame_ff;
   logic                     rsp_ev_valid_ff;
   logic [PAGE_NUMBER_W-1:0] rsp_ev_page_ff;

   logic [PAGE_NUMBER_W-1:0] page_rem;
   logic [PAGE_W-1:0]        page_idx;

   logic [NUM_FRAMES-1:0]    cell_valid;
   logic [NUM_FRAMES-1:0]    page_match;
   logic [NUM_FRAMES-1:0]    frame_match;
   logic [NUM_FRAMES-1:0]    shift;
   logic [NUM_FRAMES-1:0]    sel;
   logic [FRAME_W-1:0]       cell_frame [NUM_FRAMES];
   logic [PAGE_W-1:0]        cell_owner [NUM_FRAMES];
   logic                     nb_valid   [NUM_FRAMES];
   logic [FRAME_W-1:0]       nb_frame   [NUM_FRAMES];
   logic [PAGE_W-1:0]        nb_owner   [NUM_FRAMES];

   logic                     hit;
   logic                     full;
   logic                     fill;
   logic                     evict;
   logic                     fifo_policy;
   logic [FRAME_W-1:0]       sel_pos;
   logic [FRAME_W-1:0]       victim_frame;
   logic [PAGE_W-1:0]        victim_owner;
   logic [FRAME_W-1:0]       new_frame;
   logic [FAULT_W-1:0]       fault_in;

   assign busy = 1'b0;

   always_comb begin
      page_rem = req_page_number;
      for (int s = PAGE_NUMBER_W - 1; s >= 0; s--) begin
         if (int'(page_rem) >= (NUM_PAGES << s)) begin
            page_rem = page_rem - PAGE_NUMBER_W'(NUM_PAGES << s);
         end
      end
      page_idx = PAGE_W'(page_rem);
   end

   for (genvar g = 0; g < NUM_FRAMES; g++) begin : g_cell
      if (g == 0) begin : g_head
         assign nb_valid[g] = 1'b1;
         assign nb_frame[g] = new_frame;
         assign nb_owner[g] = page_idx;
      end else begin : g_body
         assign nb_valid[g] = cell_valid[g-1];
         assign nb_frame[g] = cell_frame[g-1];
         assign nb_owner[g] = cell_owner[g-1];
      end

      prf_cell #(
         .FRAME_W (FRAME_W),
         .PAGE_W  (PAGE_W)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .shift_en    (shift[g]),
         .in_valid    (nb_valid[g]),
         .in_frame    (nb_frame[g]),
         .in_owner    (nb_owner[g]),
         .query_page  (page_idx),
         .query_frame (fifo_ff),
         .valid       (cell_valid[g]),
         .frame       (cell_frame[g]),
         .owner       (cell_owner[g]),
         .page_match  (page_match[g]),
         .frame_match (frame_match[g])
      );
   end

   always_comb begin
      hit         = |page_match;
      full        = (filled_ff == FILL_W'(NUM_FRAMES));
      fill        = !hit && !full;
      evict       = !hit && full;
      fifo_policy = !((policy_ff == POLICY_LRU) || (policy_ff == POLICY_MRU));

      sel = '0;
      if (hit) begin
         sel = page_match;
      end else if (!full) begin
         sel[filled_ff[FRAME_W-1:0]] = 1'b1;
      end else begin
         unique case (policy_ff)
            POLICY_LRU: sel[NUM_FRAMES-1] = 1'b1;
            POLICY_MRU: sel[0] = 1'b1;
            default:    sel = frame_match;
         endcase
      end

      sel_pos      = '0;
      victim_frame = '0;
      victim_owner = '0;
      for (int p = 0; p < NUM_FRAMES; p++) begin
         if (sel[p]) begin
            sel_pos      = sel_pos | FRAME_W'(p);
            victim_frame = victim_frame | cell_frame[p];
            victim_owner = victim_owner | cell_owner[p];
         end
      end

      new_frame = fill ? filled_ff[FRAME_W-1:0] : victim_frame;

      for (int p = 0; p < NUM_FRAMES; p++) begin
         shift[p] = start && (p <= int'(sel_pos));
      end

      fault_in = (!hit && (fault_ff != '1)) ? fault_ff + 1'b1 : fault_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff    <= POLICY_FIFO;
         filled_ff    <= '0;
         fifo_ff      <= '0;
         fault_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            policy_ff <= csr_write_data;
         end
         rsp_valid_ff <= start;
         if (start) begin
            fault_ff <= fault_in;
            if (fill) begin
               filled_ff <= filled_ff + 1'b1;
            end
            if (evict && fifo_policy) begin
               fifo_ff <= (fifo_ff == FRAME_W'(NUM_FRAMES - 1)) ? '0 : fifo_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rsp_hit_ff      <= hit;
         rsp_frame_ff    <= FRAME_INDEX_W'(new_frame);
         rsp_ev_valid_ff <= evict;
         rsp_ev_page_ff  <= evict ? PAGE_NUMBER_W'(victim_owner) : '0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_frame_index   = rsp_frame_ff;
   assign rsp_evicted_valid = rsp_ev_valid_ff;
   assign rsp_evicted_page  = rsp_ev_page_ff;
   assign rsp_fault_count   = fault_ff;

endmodule

// ----- sv/prf_checker.sv -----
// Port-level checks for the page frame replacement unit, bound to its top level.
// It depends on prf_pkg and on the ports of page_frame_replacement_unit.
module prf_checker
   import prf_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     start,
   input logic                     busy,
   input logic                     rsp_valid,
   input logic                     rsp_hit,
   input logic                     rsp_evicted_valid,
   input logic [PAGE_NUMBER_W-1:0] rsp_evicted_page,
   input logic [FAULT_W-1:0]       rsp_fault_count
);

   // Every accepted request yields exactly one response in the following cycle.
   a_one_response: assert property (@(posedge clock) disable iff (reset)
      rsp_valid == ($past(start && !busy) && !$past(reset)))
      else $error("response strobe does not follow an accepted request");

   // A resident page never forces an eviction.
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_hit && rsp_evicted_valid))
      else $error("eviction reported on a hit");

   // The evicted page reads as zero when nothing was evicted.
   a_evict_page_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_evicted_valid) |-> (rsp_evicted_page == '0))
      else $error("evicted page not zero without an eviction");

   // Between back-to-back responses the fault count holds on a hit and steps on a fault until it saturates.
   a_fault_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(rsp_valid) && !$past(reset)) |->
      (rsp_hit ? (rsp_fault_count == $past(rsp_fault_count)) :
       (rsp_fault_count == (($past(rsp_fault_count) == '1) ?
                            $past(rsp_fault_count) : $past(rsp_fault_count) + 1'b1))))
      else $error("fault count does not follow the hit flag");

endmodule

bind page_frame_replacement_unit prf_checker u_prf_checker (.*);
